>>> rtl/core/fcr_pkg.sv
// Package for the frame chunk reassembler.
// Holds the limits, the chunk status codes and the map request type.
// Used by fcr_map and frame_chunk_reassembler_top.
package fcr_pkg;

	localparam int MAP_DEPTH = 1024;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);

	localparam logic [15:0] MAX_CHUNKS  = 16'd1024;
	localparam logic [15:0] MAX_PAYLOAD = 16'd2048;
	localparam logic [11:0] MAX_DIM     = 12'd2048;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_TYPE  = 3'd1,
		ST_SIZE  = 3'd2,
		ST_LIMIT = 3'd3,
		ST_INDEX = 3'd4,
		ST_DUP   = 3'd5
	} status_t;

	// Update of the received map issued when a first beat leaves stage 1.
	typedef struct packed {
		logic              valid;
		logic              clear;
		logic              set;
		logic [MAP_AW-1:0] idx;
	} map_req_t;

endpackage

>>> rtl/core/fcr_map.sv
// Received-chunk map: one bit per chunk index in a synchronous memory.
// A clear request sweeps the whole memory, one entry a cycle, and leaves the
// requested entry set if the request also sets it. Depends on fcr_pkg.
module fcr_map (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [fcr_pkg::MAP_AW-1:0] rd_idx,
	output logic                    rd_bit,
	input  fcr_pkg::map_req_t       req,
	output logic                    busy
);
	import fcr_pkg::*;

	logic              mem [MAP_DEPTH];
	logic              sweep_q;
	logic [MAP_AW-1:0] sweep_cnt_q;
	logic              keep_set_q;
	logic [MAP_AW-1:0] keep_idx_q;

	assign busy = sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b0;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
			if (sweep_cnt_q == MAP_AW'(MAP_DEPTH - 1)) begin
				sweep_q <= 1'b0;
			end
		end else if (req.valid && req.clear) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.clear) begin
			keep_set_q <= req.set;
			keep_idx_q <= req.idx;
		end
	end

	// The sweep writes every entry; the chunk that caused the clear gets its bit only if its request set it.
	always_ff @(posedge clk) begin
		if (sweep_q) begin
			mem[sweep_cnt_q] <= keep_set_q && (sweep_cnt_q == keep_idx_q);
		end else if (req.valid && !req.clear && req.set) begin
			mem[req.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_bit <= mem[rd_idx];
		end
	end

	a_no_req_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.valid)
		else $error("map update issued during clearing sweep");

	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !rd_en)
		else $error("map read issued during clearing sweep");

	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.clear && !busy) |=> busy)
		else $error("clear request did not start a sweep");

endmodule

>>> rtl/core/frame_chunk_reassembler_top.sv
// Top level of the frame chunk reassembler.
// Checks chunk headers, keeps the received map and the frame counters, and
// turns payload beats into frame-memory writes. Depends on fcr_pkg, fcr_map.
//
// Usage:
// The slave stream takes one payload byte per beat together with its chunk
// header; s_tlast marks the final beat of a chunk. The master stream gives one
// result beat per input beat, in order; m_tlast marks the chunk's last result,
// which carries the status and the counters. The config channel writes the
// chunk type code and is always ready; write it only while the block is idle.
// An accepted input beat passes the stage 1 register and the output register
// to its result beat. Throughput is one beat per cycle unless a map sweep or
// the receiver holds it. A first beat with good type and size that starts a
// new frame or changes the frame geometry clears the received map with a sweep
// of every entry; s_tready is low as that beat leaves stage 1 and in the sweep.
// A first beat reads the map as it is accepted into stage 1, before it is judged;
// a write from the beat just ahead to the same entry is forwarded.
// Reset clears all counters, the held frame state and the pipeline; the map
// needs no clearing after reset because the first chunk that passes the type
// and size checks always clears it. When the receiver stalls, the output register
// holds its beat and s_tready drops once stage 1 is also full.
module frame_chunk_reassembler_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// frame_number, pic_width, pic_height, chunk_total, chunk_number,
	// byte_offset, declared_size, payload_length, byte_pos, data_byte
	input  logic [167:0] s_tdata,
	// msg_kind
	input  logic [7:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// write_address, write_data, chunk_status, frame_complete,
	// completed_frame, chunks_so_far, all_chunks_count, all_frames_count
	output logic [143:0] m_tdata,
	// write_enable
	output logic         m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);
	import fcr_pkg::*;

	// Input field unpacking.
	logic [31:0] in_fid;
	logic [11:0] in_w, in_h;
	logic [15:0] in_total, in_idx, in_dsize, in_plen;
	logic [23:0] in_offset;
	logic [10:0] in_pos;
	logic [7:0]  in_data;
	logic [23:0] in_pix;

	assign in_fid    = s_tdata[31:0];
	assign in_w      = s_tdata[43:32];
	assign in_h      = s_tdata[55:44];
	assign in_total  = s_tdata[71:56];
	assign in_idx    = s_tdata[87:72];
	assign in_offset = s_tdata[111:88];
	assign in_dsize  = s_tdata[127:112];
	assign in_plen   = s_tdata[143:128];
	assign in_pos    = s_tdata[154:144];
	assign in_data   = s_tdata[162:155];
	assign in_pix    = in_w * in_h;

	// Stage 1 registers.
	logic        s1_valid_q;
	logic [7:0]  kind_s1;
	logic [31:0] fid_s1;
	logic [11:0] w_s1, h_s1;
	logic [15:0] total_s1, idx_s1, dsize_s1, plen_s1;
	logic [10:0] pos_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic [24:0] addr_s1;
	logic [25:0] pix3_s1;
	logic        hit_s1;

	// Held state.
	logic [7:0]  cfg_type_q;
	logic [31:0] cur_id_q;
	logic [11:0] wh_q, hh_q;
	logic [15:0] th_q;
	logic        ready_q;
	status_t     verdict_q;
	logic [10:0] count_q;
	logic [25:0] limit_q;
	logic [31:0] chunk_cnt_q, frame_cnt_q;

	// Output register.
	logic         out_valid_q;
	logic [143:0] out_data_q;
	logic         out_we_q;
	logic         out_last_q;

	// Stage 1 evaluation.
	logic        first, type_bad, size_bad, pass_hdr, fid_new, dim_chg, lim_bad;
	logic        clear_need, seen, idx_bad, take, frame_done, we;
	logic [31:0] id_n, chunk_cnt_n, frame_cnt_n;
	logic [11:0] wh_n, hh_n;
	logic [15:0] th_n;
	logic        ready_n;
	logic [25:0] limit_n;
	logic [10:0] count_base, count_n;
	status_t     verdict_n;

	logic        map_bit, map_busy;
	map_req_t    map_req;
	logic        s1_adv, in_acc;

	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !map_busy && (!s1_valid_q || (s1_adv && !clear_need));
	assign in_acc   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		first    = (pos_s1 == 11'd0);
		type_bad = (kind_s1 != cfg_type_q);
		size_bad = (dsize_s1 > MAX_PAYLOAD) || (plen_s1 != dsize_s1);
		pass_hdr = first && !type_bad && !size_bad;
		fid_new  = (fid_s1 != cur_id_q);
		dim_chg  = !ready_q || (w_s1 != wh_q) || (h_s1 != hh_q) || (total_s1 != th_q);
		lim_bad  = (w_s1 > MAX_DIM) || (h_s1 > MAX_DIM) || (total_s1 > MAX_CHUNKS);
		clear_need = pass_hdr && (fid_new || dim_chg);

		id_n    = pass_hdr ? fid_s1 : cur_id_q;
		wh_n    = (pass_hdr && dim_chg) ? w_s1 : wh_q;
		hh_n    = (pass_hdr && dim_chg) ? h_s1 : hh_q;
		th_n    = (pass_hdr && dim_chg) ? total_s1 : th_q;
		ready_n = (pass_hdr && dim_chg) ? !lim_bad : ready_q;
		limit_n = (pass_hdr && dim_chg) ? pix3_s1 : limit_q;

		count_base = clear_need ? 11'd0 : count_q;
		seen       = !clear_need && (map_bit || hit_s1);
		idx_bad    = (idx_s1 >= th_n);

		if (!first) begin
			verdict_n = verdict_q;
		end else if (type_bad) begin
			verdict_n = ST_TYPE;
		end else if (size_bad) begin
			verdict_n = ST_SIZE;
		end else if (dim_chg && lim_bad) begin
			verdict_n = ST_LIMIT;
		end else if (idx_bad) begin
			verdict_n = ST_INDEX;
		end else if (seen) begin
			verdict_n = ST_DUP;
		end else begin
			verdict_n = ST_OK;
		end

		take        = first && (verdict_n == ST_OK);
		count_n     = take ? count_base + 11'd1 : count_base;
		chunk_cnt_n = take ? chunk_cnt_q + 32'd1 : chunk_cnt_q;
		frame_done  = take && ({5'd0, count_n} == th_n);
		frame_cnt_n = frame_done ? frame_cnt_q + 32'd1 : frame_cnt_q;

		we = (verdict_n == ST_OK) && ready_n && ({5'd0, pos_s1} < dsize_s1)
			&& ({1'b0, addr_s1} < limit_n);
	end

	always_comb begin
		map_req.valid = s1_adv && first;
		map_req.clear = clear_need;
		map_req.set   = take;
		map_req.idx   = idx_s1[MAP_AW-1:0];
	end

	fcr_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc),
		.rd_idx (in_idx[MAP_AW-1:0]),
		.rd_bit (map_bit),
		.req    (map_req),
		.busy   (map_busy)
	);

	// Stage 1 capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1  <= s_tuser;
			fid_s1   <= in_fid;
			w_s1     <= in_w;
			h_s1     <= in_h;
			total_s1 <= in_total;
			idx_s1   <= in_idx;
			dsize_s1 <= in_dsize;
			plen_s1  <= in_plen;
			pos_s1   <= in_pos;
			data_s1  <= in_data;
			last_s1  <= s_tlast;
			addr_s1  <= {1'b0, in_offset} + {14'd0, in_pos};
			pix3_s1  <= {2'b00, in_pix} + {1'b0, in_pix, 1'b0};
			// The map write of the beat leaving now lands after this read.
			hit_s1   <= s1_adv && take && (idx_s1[MAP_AW-1:0] == in_idx[MAP_AW-1:0]);
		end
	end

	// Held frame state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_type_q  <= '0;
			cur_id_q    <= '0;
			wh_q        <= '0;
			hh_q        <= '0;
			th_q        <= '0;
			ready_q     <= 1'b0;
			verdict_q   <= ST_OK;
			count_q     <= '0;
			limit_q     <= '0;
			chunk_cnt_q <= '0;
			frame_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				cfg_type_q <= cfg_data;
			end
			if (s1_adv) begin
				cur_id_q    <= id_n;
				wh_q        <= wh_n;
				hh_q        <= hh_n;
				th_q        <= th_n;
				ready_q     <= ready_n;
				verdict_q   <= verdict_n;
				count_q     <= count_n;
				limit_q     <= limit_n;
				chunk_cnt_q <= chunk_cnt_n;
				frame_cnt_q <= frame_cnt_n;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_we_q   <= we;
			out_last_q <= last_s1;
			out_data_q[23:0]  <= we ? addr_s1[23:0] : 24'd0;
			out_data_q[31:24] <= we ? data_s1 : 8'd0;
			if (last_s1) begin
				out_data_q[34:32]   <= verdict_n;
				out_data_q[35]      <= (verdict_n == ST_OK) && ({5'd0, count_n} == th_n);
				out_data_q[67:36]   <= id_n;
				out_data_q[78:68]   <= count_n;
				out_data_q[110:79]  <= chunk_cnt_n;
				out_data_q[142:111] <= frame_cnt_n;
			end else begin
				out_data_q[142:32] <= '0;
			end
			out_data_q[143] <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_we_q;
	assign m_tlast  = out_last_q;

endmodule

>>> tb/sv/frame_chunk_reassembler_top_test.sv
// Self-checking testbench for frame_chunk_reassembler_top.
// Drives chunk payload beats with random idling, predicts every result beat
// with its own model of the reassembler, and depends only on fcr_pkg and the RTL.
`timescale 1ns / 1ps

module frame_chunk_reassembler_top_test;
	import fcr_pkg::*;

	localparam logic [7:0] DIR_CODE = 8'h3C;
	localparam int PHASE_BEATS = 335;
	localparam int HOLD_AT = 500;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [7:0]  kind;
		logic [31:0] frame_num;
		logic [11:0] pic_w;
		logic [11:0] pic_h;
		logic [15:0] total;
		logic [15:0] chunk_idx;
		logic [23:0] offset;
		logic [15:0] dsize;
		logic [15:0] plen;
		logic [10:0] pos;
		logic [7:0]  data;
		logic        last;
	} chunk_beat_t;

	typedef struct {
		logic        we;
		logic [23:0] addr;
		logic [7:0]  wdata;
		logic        done;
		logic [2:0]  status;
		logic        complete;
		logic [31:0] frame;
		logic [10:0] so_far;
		logic [31:0] chunk_cnt;
		logic [31:0] frame_cnt;
	} mem_write_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;
	logic [7:0]   s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_data = '0;

	frame_chunk_reassembler_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Stimulus and expectation stores.
	chunk_beat_t chunk_beats[$];
	mem_write_t  pending_writes[$];
	chunk_beat_t on_bus;

	int unsigned drv_issued = 0;
	int unsigned in_accepted = 0;
	int unsigned res_count = 0;
	int unsigned sink_seen = 0;
	int          src_wait = 0;
	int          sink_wait = 0;
	bit          src_calm = 1'b0;
	bit          sink_calm = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          fail_count = 0;

	// Model of the reassembler state.
	logic [7:0]  type_code = '0;
	bit          map_seen [MAP_DEPTH];
	logic [31:0] frame_chunks = '0;
	logic [31:0] cur_frame = '0;
	logic [11:0] held_w = '0;
	logic [11:0] held_h = '0;
	logic [15:0] held_total = '0;
	bit          store_up = 1'b0;
	status_t     verdict = ST_OK;
	logic [31:0] chunks_accepted = '0;
	logic [31:0] frames_done = '0;
	int          outcome_count [6];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic void wipe_map();
		foreach (map_seen[i]) map_seen[i] = 1'b0;
		frame_chunks = '0;
	endfunction

	// Header checks run on the first byte of a chunk only; later bytes reuse the
	// verdict that the last first byte left behind.
	function automatic mem_write_t reassemble_beat(input chunk_beat_t b);
		mem_write_t      r;
		longint unsigned addr;
		longint unsigned lim;
		bit              fresh;
		if (b.pos == 0) begin
			if (b.kind != type_code) begin
				verdict = ST_TYPE;
			end else if (b.dsize > MAX_PAYLOAD || b.plen != b.dsize) begin
				verdict = ST_SIZE;
			end else begin
				if (b.frame_num != cur_frame) begin
					cur_frame = b.frame_num;
					wipe_map();
				end
				fresh = !store_up || b.pic_w != held_w || b.pic_h != held_h ||
					b.total != held_total;
				if (fresh) begin
					held_w = b.pic_w;
					held_h = b.pic_h;
					held_total = b.total;
					wipe_map();
					store_up = b.pic_w <= MAX_DIM && b.pic_h <= MAX_DIM &&
						b.total <= MAX_CHUNKS;
				end
				if (fresh && !store_up) begin
					verdict = ST_LIMIT;
				end else if (b.chunk_idx >= held_total) begin
					verdict = ST_INDEX;
				end else if (map_seen[b.chunk_idx[9:0]]) begin
					verdict = ST_DUP;
				end else begin
					map_seen[b.chunk_idx[9:0]] = 1'b1;
					frame_chunks++;
					chunks_accepted++;
					if (frame_chunks == held_total) frames_done++;
					verdict = ST_OK;
				end
			end
			outcome_count[verdict]++;
		end
		lim = longint'(held_w) * longint'(held_h) * 3;
		addr = longint'(b.offset) + longint'(b.pos);
		r.we = verdict == ST_OK && store_up && b.pos < b.dsize && addr < lim;
		r.addr = r.we ? addr[23:0] : '0;
		r.wdata = r.we ? b.data : '0;
		r.done = b.last;
		if (b.last) begin
			r.status = verdict;
			r.complete = verdict == ST_OK && frame_chunks == held_total;
			r.frame = cur_frame;
			r.so_far = frame_chunks[10:0];
			r.chunk_cnt = chunks_accepted;
			r.frame_cnt = frames_done;
		end else begin
			r.status = '0;
			r.complete = 1'b0;
			r.frame = '0;
			r.so_far = '0;
			r.chunk_cnt = '0;
			r.frame_cnt = '0;
		end
		return r;
	endfunction

	function automatic chunk_beat_t make_hdr(input logic [7:0] kind,
			input logic [31:0] fid, input logic [11:0] w_px, input logic [11:0] h_px,
			input logic [15:0] total, input logic [15:0] idx, input logic [23:0] offset,
			input logic [15:0] dsize, input logic [15:0] plen);
		chunk_beat_t b;
		b.kind = kind;
		b.frame_num = fid;
		b.pic_w = w_px;
		b.pic_h = h_px;
		b.total = total;
		b.chunk_idx = idx;
		b.offset = offset;
		b.dsize = dsize;
		b.plen = plen;
		b.pos = '0;
		b.data = '0;
		b.last = 1'b0;
		return b;
	endfunction

	task automatic push_run(input chunk_beat_t h, input int from_pos, input int count,
			input bit marked);
		chunk_beat_t b;
		int          p;
		b = h;
		for (p = 0; p < count; p++) begin
			b.pos = 11'(from_pos + p);
			b.data = 8'($urandom);
			b.last = marked && p == count - 1;
			chunk_beats.push_back(b);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 40)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic write_type_code(input logic [7:0] code);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		type_code = code;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Every beat yields one result, so an empty store means the block is idle.
	task automatic wait_idle();
		do @(negedge clk);
		while (chunk_beats.size() != 0 || drv_issued != in_accepted ||
			pending_writes.size() != 0);
	endtask

	// Sender: a new beat goes out after its drawn gap; the long receiver hold-off
	// suppresses gaps so the pipeline backs up into s_tready.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && in_accepted == drv_issued) src_wait = draw_gap(src_calm);
			if (!s_tvalid || in_accepted == drv_issued) begin
				if (src_wait > 0 && hold_left == 0) begin
					src_wait--;
					s_tvalid <= 1'b0;
				end else if (chunk_beats.size() != 0) begin
					on_bus = chunk_beats.pop_front();
					drv_issued++;
					if (drv_issued % 64 == 0) src_calm = $urandom_range(0, 3) == 0;
					s_tdata <= {5'd0, on_bus.data, on_bus.pos, on_bus.plen, on_bus.dsize,
						on_bus.offset, on_bus.chunk_idx, on_bus.total, on_bus.pic_h,
						on_bus.pic_w, on_bus.frame_num};
					s_tuser <= on_bus.kind;
					s_tlast <= on_bus.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && res_count >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done = 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_count != sink_seen) begin
				sink_seen = res_count;
				if (res_count % 64 == 0) sink_calm = $urandom_range(0, 3) == 0;
				sink_wait = draw_gap(sink_calm);
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Results are checked before the input beat of the same edge is predicted,
	// so the store always pops the oldest expectation.
	always @(posedge clk) begin : monitor
		mem_write_t want;
		mem_write_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				res_count++;
				got.we = m_tuser;
				got.addr = m_tdata[23:0];
				got.wdata = m_tdata[31:24];
				got.done = m_tlast;
				got.status = m_tdata[34:32];
				got.complete = m_tdata[35];
				got.frame = m_tdata[67:36];
				got.so_far = m_tdata[78:68];
				got.chunk_cnt = m_tdata[110:79];
				got.frame_cnt = m_tdata[142:111];
				if (pending_writes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat, expected nothing, actual %0h",
						$time, m_tdata);
				end else begin
					want = pending_writes.pop_front();
					check_field("write_enable", 32'(want.we), 32'(got.we));
					check_field("write_address", 32'(want.addr), 32'(got.addr));
					check_field("write_data", 32'(want.wdata), 32'(got.wdata));
					check_field("chunk_done", 32'(want.done), 32'(got.done));
					check_field("chunk_status", 32'(want.status), 32'(got.status));
					check_field("frame_complete", 32'(want.complete), 32'(got.complete));
					check_field("completed_frame", want.frame, got.frame);
					check_field("chunks_so_far", 32'(want.so_far), 32'(got.so_far));
					check_field("all_chunks_count", want.chunk_cnt, got.chunk_cnt);
					check_field("all_frames_count", want.frame_cnt, got.frame_cnt);
				end
			end
			if (s_tvalid && s_tready) begin
				in_accepted++;
				pending_writes.push_back(reassemble_beat(on_bus));
			end
		end
	end

	initial begin : stimulus
		chunk_beat_t h;
		int          order[$];
		logic [7:0]  codes [4];
		logic [7:0]  code;
		logic [31:0] stim_fid;
		logic [11:0] stim_w;
		logic [11:0] stim_h;
		logic [15:0] stim_total;
		int          ph;
		int          pick;
		int          k;
		int          j;
		int          tmp;
		int          n;
		int          csize;
		int          defect;
		foreach (outcome_count[i]) outcome_count[i] = 0;
		stim_fid = '0;
		stim_w = 12'd1;
		stim_h = 12'd1;
		stim_total = 16'd1;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: header rejections in check order, the largest legal frame with
		// a write that crosses the end of the store, then a small frame to completion.
		write_type_code(DIR_CODE);
		h = make_hdr(~DIR_CODE, 32'd1, 12'd4, 12'd4, 16'd2, 16'd0, 24'd0, 16'd1, 16'd1);
		push_run(h, 0, 1, 1);
		h = make_hdr(DIR_CODE, 32'd1, 12'd4, 12'd4, 16'd2, 16'd0, 24'd0, 16'd2049, 16'd2049);
		push_run(h, 0, 1, 1);
		h.dsize = 16'd2;
		h.plen = 16'd3;
		push_run(h, 0, 2, 1);
		h = make_hdr(DIR_CODE, 32'd5, 12'd2049, 12'd1, 16'd1, 16'd0, 24'd0, 16'd1, 16'd1);
		push_run(h, 0, 1, 1);
		h.pic_w = 12'd1;
		h.pic_h = 12'hFFF;
		push_run(h, 0, 1, 1);
		h.pic_h = 12'd1;
		h.total = 16'd1025;
		push_run(h, 0, 1, 1);
		h.pic_w = 12'd4;
		h.pic_h = 12'd4;
		h.total = 16'd0;
		push_run(h, 0, 1, 1);
		h = make_hdr(DIR_CODE, 32'hFFFF_FFFF, 12'd2048, 12'd2048, 16'd1024, 16'd1023,
			24'hBFFFFE, 16'd3, 16'd3);
		push_run(h, 0, 3, 1);
		h.dsize = 16'd1;
		h.plen = 16'd1;
		push_run(h, 0, 1, 1);
		h.chunk_idx = 16'd1024;
		push_run(h, 0, 1, 1);
		h.chunk_idx = 16'hFFFF;
		h.offset = 24'hFFFFFF;
		push_run(h, 0, 1, 1);
		h.chunk_idx = 16'd0;
		h.offset = 24'd0;
		h.dsize = 16'd0;
		h.plen = 16'd0;
		push_run(h, 0, 1, 1);
		h.chunk_idx = 16'd1;
		h.dsize = 16'd1;
		h.plen = 16'd1;
		push_run(h, 0, 2, 1);
		// A lone byte at the top position, with no first byte ahead of it.
		h.chunk_idx = 16'd2;
		h.dsize = 16'd2048;
		h.plen = 16'd2048;
		push_run(h, 2047, 1, 1);
		h = make_hdr(DIR_CODE, 32'd0, 12'd1, 12'd1, 16'd1, 16'd0, 24'd1, 16'd3, 16'd3);
		push_run(h, 0, 3, 1);
		h.total = 16'd2;
		h.chunk_idx = 16'd1;
		h.offset = 24'd0;
		h.dsize = 16'd1;
		h.plen = 16'd1;
		push_run(h, 0, 1, 1);
		h.chunk_idx = 16'd0;
		push_run(h, 0, 1, 1);
		wait_idle();

		codes[0] = 8'hFF;
		codes[1] = 8'($urandom);
		codes[2] = 8'h00;
		codes[3] = 8'($urandom);
		for (ph = 0; ph < 4; ph++) begin
			code = codes[ph];
			write_type_code(code);
			while (chunk_beats.size() < PHASE_BEATS) begin
				pick = $urandom_range(0, 99);
				if (pick < 78) begin
					// Whole frame, chunks shuffled, with an occasional defect.
					if ($urandom_range(0, 1)) stim_fid = stim_fid + 1;
					else stim_fid = $urandom;
					stim_w = 12'($urandom_range(1, 16));
					stim_h = 12'($urandom_range(1, 16));
					stim_total = 16'($urandom_range(1, 8));
					csize = $urandom_range(0, 5);
					n = (csize == 0) ? 1 : csize;
					order.delete();
					for (k = 0; k < stim_total; k++) order.push_back(k);
					for (k = order.size() - 1; k > 0; k--) begin
						j = $urandom_range(0, k);
						tmp = order[k];
						order[k] = order[j];
						order[j] = tmp;
					end
					for (k = 0; k < order.size(); k++) begin
						h = make_hdr(code, stim_fid, stim_w, stim_h, stim_total,
							16'(order[k]), 24'(order[k] * csize), 16'(csize), 16'(csize));
						if ($urandom_range(0, 7) == 0)
							h.offset = 24'(h.offset + $urandom_range(0, 64));
						defect = $urandom_range(0, 24);
						if (defect == 0) begin
							h.chunk_idx = 16'(order[$urandom_range(0, k)]);
							push_run(h, 0, n, 1);
							h.chunk_idx = 16'(order[k]);
						end else if (defect == 1) begin
							h.chunk_idx = 16'(stim_total + $urandom_range(0, 3));
							push_run(h, 0, n, 1);
							h.chunk_idx = 16'(order[k]);
						end
						if (defect == 2) h.kind = code ^ (8'd1 << $urandom_range(0, 7));
						if (defect == 3) h.plen = 16'(csize + 1);
						if (defect != 4) push_run(h, 0, n + ($urandom_range(0, 7) == 0), 1);
					end
				end else if (pick < 90) begin
					h.kind = $urandom_range(0, 1) ? code : 8'($urandom);
					h.frame_num = $urandom_range(0, 1) ? stim_fid : $urandom;
					h.pic_w = 12'($urandom_range(0, 4095));
					h.pic_h = 12'($urandom_range(0, 4095));
					h.total = 16'($urandom_range(0, 65535));
					h.chunk_idx = 16'($urandom_range(0, 65535));
					h.offset = 24'($urandom_range(0, 24'hFFFFFF));
					h.dsize = 16'($urandom_range(0, 65535));
					h.plen = 16'($urandom_range(0, 65535));
					if ($urandom_range(0, 3) == 0) begin
						h.dsize = 16'($urandom_range(0, 8));
						h.plen = h.dsize;
					end
					push_run(h, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 2047), 1,
						1'($urandom_range(0, 1)));
				end else begin
					h = make_hdr(code, stim_fid, stim_w, stim_h, stim_total,
						16'($urandom_range(0, stim_total)), 24'd0, 16'd3, 16'd3);
					case ($urandom_range(0, 4))
						0: push_run(h, 1, 2, 1);
						1: push_run(h, 0, 3, 0);
						2: begin
							h.frame_num = stim_fid - 1;
							push_run(h, 0, 3, 1);
						end
						3: begin
							h.pic_w = 12'(stim_w + 1);
							push_run(h, 0, 3, 1);
						end
						default: begin
							h.pic_w = 12'($urandom_range(2049, 4095));
							push_run(h, 0, 1, 1);
						end
					endcase
				end
			end
			wait_idle();
		end

		repeat (4) @(posedge clk);
		$display("Checked %0d result beats from %0d input beats;", res_count, in_accepted);
		$display("%0d chunks accepted, %0d frames completed, verdicts %0d/%0d/%0d/%0d/%0d/%0d.",
			chunks_accepted, frames_done,
			outcome_count[ST_OK], outcome_count[ST_TYPE], outcome_count[ST_SIZE],
			outcome_count[ST_LIMIT], outcome_count[ST_INDEX], outcome_count[ST_DUP]);
		if (fail_count == 0 && pending_writes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
